[rtl/core/imht_pkg.sv]
// ----------------------------------------------------------------------------
// imht_pkg
// Shared types, constants and codes of the indexed min-heap timer core.
// ----------------------------------------------------------------------------
package imht_pkg;

  localparam int CAPACITY     = 32;
  localparam int HANDLE_COUNT = 1024;
  localparam int TIME_W       = 32;
  localparam int SLOT_W       = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int HND_W        = 10;
  localparam int TMO_W        = 30;
  localparam int ELAPSED_W    = 16;
  localparam int KIND_W       = 3;
  localparam int NEXT_W       = 31;
  localparam logic [TIME_W-1:0] NEXT_MAX = TIME_W'(1073741823);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TIME_W-1:0] time_t;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_ADJUST = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED    = 3'd0,
    KIND_OK       = 3'd1,
    KIND_NOTFOUND = 3'd2,
    KIND_FULL     = 3'd3,
    KIND_REPORT   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [HND_W-1:0] hnd;
    time_t            key;
  } heap_ent_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_RD_SLOT,
    OP_SET_REKEY,
    OP_SET_INSERT,
    OP_REM_POS,
    OP_REM_ROOT,
    OP_REM_LOAD,
    OP_RD_LEFT,
    OP_RD_RIGHT,
    OP_DOWN_STEP,
    OP_RD_PARENT,
    OP_UP_STEP,
    OP_PLACE,
    OP_RD_ROOT,
    OP_EMIT_OK,
    OP_EMIT_NF,
    OP_EMIT_FULL,
    OP_EMIT_FIRE_CMD,
    OP_EMIT_FIRE_ROOT,
    OP_EMIT_REPORT
  } dp_op_t;

  typedef struct packed {
    cmd_t cmd;
    logic here;
    logic full;
    logic cnt_zero;
    logic slot_zero;
    logic down_end;
    logic down_stop;
    logic up_stop;
    logic moved;
    logic tail;
    logic expired;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_POS_WAIT,
    S_DECIDE,
    S_T_CHK,
    S_T_EVAL,
    S_EMIT_FIRE_ROOT,
    S_REM_ROOT,
    S_EMIT_FIRE_CMD,
    S_REM_POS,
    S_REM_CHK,
    S_DN,
    S_DN_R,
    S_DN_CMP,
    S_UP,
    S_UP_CMP,
    S_PLACE,
    S_DONE,
    S_EMIT_OK,
    S_EMIT_NF,
    S_EMIT_FULL,
    S_EMIT_RPT
  } state_t;

  function automatic logic precedes(time_t a, time_t b);
    time_t d;
    d = a - b;
    return d[TIME_W-1];
  endfunction

endpackage

[rtl/core/indexed_min_heap_timer_core.sv]
// ----------------------------------------------------------------------------
// indexed_min_heap_timer_core
// Timer store kept as a binary min-heap by expiry, with a per-handle position
// table; start, adjust, cancel and tick commands.
// ----------------------------------------------------------------------------
// channel  dir  handshake            word
// in       in   in_valid / in_ready  command, handle, timeout_ms, elapsed_ms
// out      out  out_valid / out_ready kind, fired_handle, next_ms, last
//
// one word at a time; lookup reads the position table and then the heap, each sift level
// down reads both children and each level up reads the parent over the single heap read
// port, and a tick fires expired handles one by one before its report word
// no clearing pass after reset: presence is checked against the heap itself
// a full result register stalls the sequencer until out_ready
// ----------------------------------------------------------------------------
module indexed_min_heap_timer_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         command,
  input  logic [imht_pkg::HND_W-1:0]         handle,
  input  logic [imht_pkg::TMO_W-1:0]         timeout_ms,
  input  logic [imht_pkg::ELAPSED_W-1:0]     elapsed_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [imht_pkg::KIND_W-1:0]        kind,
  output logic [imht_pkg::HND_W-1:0]         fired_handle,
  output logic signed [imht_pkg::NEXT_W-1:0] next_ms,
  output logic                               last
);
  import imht_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  imht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .stat     (stat),
    .op       (op)
  );

  imht_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .stat         (stat),
    .command      (command),
    .handle       (handle),
    .timeout_ms   (timeout_ms),
    .elapsed_ms   (elapsed_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .fired_handle (fired_handle),
    .next_ms      (next_ms),
    .last         (last)
  );

endmodule

[rtl/core/imht_ctrl.sv]
// ----------------------------------------------------------------------------
// imht_ctrl
// Command sequencer: walks each command through handle lookup or root check, sift and result words.
// ----------------------------------------------------------------------------
module imht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  imht_pkg::dp_stat_t stat,
  output imht_pkg::dp_op_t   op
);
  import imht_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_ACCEPT;
          state_next = (cmd_t'(command) == CMD_TICK) ? S_T_CHK : S_POS_WAIT;
        end
      end
      S_POS_WAIT: begin
        op         = OP_RD_SLOT;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (stat.cmd)
          CMD_START: begin
            if (stat.here) begin
              op         = OP_SET_REKEY;
              state_next = S_DN;
            end else if (stat.full) begin
              state_next = S_EMIT_FULL;
            end else begin
              op         = OP_SET_INSERT;
              state_next = S_UP;
            end
          end
          CMD_ADJUST: begin
            if (stat.here) begin
              op         = OP_SET_REKEY;
              state_next = S_DN;
            end else begin
              state_next = S_EMIT_NF;
            end
          end
          default: begin
            if (stat.here) begin
              state_next = S_EMIT_FIRE_CMD;
            end else begin
              state_next = S_EMIT_NF;
            end
          end
        endcase
      end
      S_T_CHK: begin
        if (stat.cnt_zero) begin
          state_next = S_EMIT_RPT;
        end else begin
          op         = OP_RD_ROOT;
          state_next = S_T_EVAL;
        end
      end
      S_T_EVAL: begin
        state_next = stat.expired ? S_EMIT_FIRE_ROOT : S_EMIT_RPT;
      end
      S_EMIT_FIRE_ROOT: begin
        op = OP_EMIT_FIRE_ROOT;
        if (stat.out_free) begin
          state_next = S_REM_ROOT;
        end
      end
      S_REM_ROOT: begin
        op         = OP_REM_ROOT;
        state_next = S_REM_CHK;
      end
      S_EMIT_FIRE_CMD: begin
        op = OP_EMIT_FIRE_CMD;
        if (stat.out_free) begin
          state_next = S_REM_POS;
        end
      end
      S_REM_POS: begin
        op         = OP_REM_POS;
        state_next = S_REM_CHK;
      end
      S_REM_CHK: begin
        if (stat.tail) begin
          op         = OP_REM_LOAD;
          state_next = S_DN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DN: begin
        if (stat.down_end) begin
          state_next = stat.moved ? S_PLACE : S_UP;
        end else begin
          op         = OP_RD_LEFT;
          state_next = S_DN_R;
        end
      end
      S_DN_R: begin
        op         = OP_RD_RIGHT;
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat.down_stop) begin
          state_next = stat.moved ? S_PLACE : S_UP;
        end else begin
          op         = OP_DOWN_STEP;
          state_next = S_DN;
        end
      end
      S_UP: begin
        if (stat.slot_zero) begin
          state_next = S_PLACE;
        end else begin
          op         = OP_RD_PARENT;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_stop) begin
          state_next = S_PLACE;
        end else begin
          op         = OP_UP_STEP;
          state_next = S_UP;
        end
      end
      S_PLACE: begin
        op         = OP_PLACE;
        state_next = S_DONE;
      end
      S_DONE: begin
        unique case (stat.cmd)
          CMD_CANCEL: state_next = S_IDLE;
          CMD_TICK:   state_next = S_T_CHK;
          default:    state_next = S_EMIT_OK;
        endcase
      end
      S_EMIT_OK: begin
        op = OP_EMIT_OK;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT_NF: begin
        op = OP_EMIT_NF;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT_FULL: begin
        op = OP_EMIT_FULL;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT_RPT: begin
        op = OP_EMIT_REPORT;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/imht_dpath.sv]
// ----------------------------------------------------------------------------
// imht_dpath
// Heap and position memories, sift registers, clock and result word register.
// ----------------------------------------------------------------------------
module imht_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  imht_pkg::dp_op_t                   op,
  output imht_pkg::dp_stat_t                 stat,
  input  logic [1:0]                         command,
  input  logic [imht_pkg::HND_W-1:0]         handle,
  input  logic [imht_pkg::TMO_W-1:0]         timeout_ms,
  input  logic [imht_pkg::ELAPSED_W-1:0]     elapsed_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [imht_pkg::KIND_W-1:0]        kind,
  output logic [imht_pkg::HND_W-1:0]         fired_handle,
  output logic signed [imht_pkg::NEXT_W-1:0] next_ms,
  output logic                               last
);
  import imht_pkg::*;

  heap_ent_t        heap_mem [CAPACITY];
  slot_t            pos_mem  [HANDLE_COUNT];

  cmd_t             cmd_q;
  logic [HND_W-1:0] hnd_q;
  logic [TMO_W-1:0] tmo_q;
  time_t            cur_time;
  cnt_t             count;
  slot_t            slot_i;
  time_t            mkey;
  logic [HND_W-1:0] mh;
  logic             moved;
  heap_ent_t        left_q;
  heap_ent_t        heap_rd;
  slot_t            pos_rd;

  logic             out_v;
  kind_t            out_kind;
  logic [HND_W-1:0] out_hnd;
  logic [NEXT_W-1:0] out_next;
  logic             out_last;

  logic             heap_re, heap_we, pos_re, pos_we;
  slot_t            heap_raddr, heap_waddr, pos_wdata;
  heap_ent_t        heap_wdata;
  logic [HND_W-1:0] pos_raddr, pos_waddr;

  logic [SLOT_W+1:0] left_w, right_w;
  logic              take_right;
  heap_ent_t         child;
  slot_t             parent;
  time_t             expiry, rem, rem_sat;
  logic              out_free, emit;
  kind_t             emit_kind;
  logic [HND_W-1:0]  emit_hnd;
  logic [NEXT_W-1:0] emit_next;
  logic              emit_last;

  assign left_w     = {1'b0, slot_i, 1'b1};
  assign right_w    = left_w + 1'b1;
  assign take_right = (right_w < {1'b0, count}) && precedes(heap_rd.key, left_q.key);
  assign child      = take_right ? heap_rd : left_q;
  assign parent     = slot_t'((slot_i - 1'b1) >> 1);
  assign expiry     = cur_time + TIME_W'(tmo_q);
  assign rem        = heap_rd.key - cur_time;
  assign out_free   = !out_v || out_ready;

  always_comb begin
    if (rem[TIME_W-1]) begin
      rem_sat = '0;
    end else if (rem > NEXT_MAX) begin
      rem_sat = NEXT_MAX;
    end else begin
      rem_sat = rem;
    end
  end

  always_comb begin
    stat.cmd       = cmd_q;
    stat.here      = ({1'b0, pos_rd} < count) && (heap_rd.hnd == hnd_q);
    stat.full      = (count == CNT_W'(CAPACITY));
    stat.cnt_zero  = (count == '0);
    stat.slot_zero = (slot_i == '0);
    stat.down_end  = (left_w >= {1'b0, count});
    stat.down_stop = precedes(mkey, child.key);
    stat.up_stop   = precedes(heap_rd.key, mkey);
    stat.moved     = moved;
    stat.tail      = ({1'b0, slot_i} < count);
    stat.expired   = (rem == '0) || rem[TIME_W-1];
    stat.out_free  = out_free;
  end

  // memory port control
  always_comb begin
    heap_re    = 1'b0;
    heap_raddr = '0;
    heap_we    = 1'b0;
    heap_waddr = slot_i;
    heap_wdata = heap_rd;
    pos_re     = 1'b0;
    pos_raddr  = handle;
    pos_we     = 1'b0;
    pos_waddr  = heap_rd.hnd;
    pos_wdata  = slot_i;
    case (op)
      OP_ACCEPT: begin
        pos_re = 1'b1;
      end
      OP_RD_SLOT: begin
        heap_re    = 1'b1;
        heap_raddr = pos_rd;
      end
      OP_REM_POS, OP_REM_ROOT: begin
        heap_re    = 1'b1;
        heap_raddr = slot_t'(count - 1'b1);
      end
      OP_RD_LEFT: begin
        heap_re    = 1'b1;
        heap_raddr = left_w[SLOT_W-1:0];
      end
      OP_RD_RIGHT: begin
        heap_re    = 1'b1;
        heap_raddr = right_w[SLOT_W-1:0];
      end
      OP_RD_PARENT: begin
        heap_re    = 1'b1;
        heap_raddr = parent;
      end
      OP_RD_ROOT: begin
        heap_re = 1'b1;
      end
      OP_DOWN_STEP: begin
        heap_we    = 1'b1;
        heap_wdata = child;
        pos_we     = 1'b1;
        pos_waddr  = child.hnd;
      end
      OP_UP_STEP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      OP_PLACE: begin
        heap_we    = 1'b1;
        heap_wdata = '{hnd: mh, key: mkey};
        pos_we     = 1'b1;
        pos_waddr  = mh;
      end
      default: begin
        heap_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    if (heap_re) begin
      heap_rd <= heap_mem[heap_raddr];
    end
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    if (pos_re) begin
      pos_rd <= pos_mem[pos_raddr];
    end
  end

  // count, clock and command registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      cur_time <= '0;
      cmd_q    <= CMD_START;
    end else begin
      case (op)
        OP_ACCEPT: begin
          cmd_q <= cmd_t'(command);
          if (cmd_t'(command) == CMD_TICK) begin
            cur_time <= cur_time + TIME_W'(elapsed_ms);
          end
        end
        OP_SET_INSERT: begin
          count <= count + 1'b1;
        end
        OP_REM_POS, OP_REM_ROOT: begin
          count <= count - 1'b1;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        hnd_q <= handle;
        tmo_q <= timeout_ms;
      end
      OP_SET_REKEY: begin
        slot_i <= pos_rd;
        mkey   <= expiry;
        mh     <= hnd_q;
        moved  <= 1'b0;
      end
      OP_SET_INSERT: begin
        slot_i <= slot_t'(count);
        mkey   <= expiry;
        mh     <= hnd_q;
        moved  <= 1'b0;
      end
      OP_REM_POS: begin
        slot_i <= pos_rd;
      end
      OP_REM_ROOT: begin
        slot_i <= '0;
      end
      OP_REM_LOAD: begin
        mkey  <= heap_rd.key;
        mh    <= heap_rd.hnd;
        moved <= 1'b0;
      end
      OP_RD_RIGHT: begin
        left_q <= heap_rd;
      end
      OP_DOWN_STEP: begin
        slot_i <= take_right ? right_w[SLOT_W-1:0] : left_w[SLOT_W-1:0];
        moved  <= 1'b1;
      end
      OP_UP_STEP: begin
        slot_i <= parent;
      end
      default: begin
        moved <= moved;
      end
    endcase
  end

  // result word register
  always_comb begin
    emit      = 1'b1;
    emit_kind = KIND_OK;
    emit_hnd  = '0;
    emit_next = '0;
    emit_last = 1'b1;
    case (op)
      OP_EMIT_OK: begin
        emit_kind = KIND_OK;
      end
      OP_EMIT_NF: begin
        emit_kind = KIND_NOTFOUND;
      end
      OP_EMIT_FULL: begin
        emit_kind = KIND_FULL;
      end
      OP_EMIT_FIRE_CMD: begin
        emit_kind = KIND_FIRED;
        emit_hnd  = hnd_q;
      end
      OP_EMIT_FIRE_ROOT: begin
        emit_kind = KIND_FIRED;
        emit_hnd  = heap_rd.hnd;
        emit_last = 1'b0;
      end
      OP_EMIT_REPORT: begin
        emit_kind = KIND_REPORT;
        emit_next = (count == '0) ? '1 : NEXT_W'(rem_sat);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (emit && out_free) begin
      out_v <= 1'b1;
    end else if (out_ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      out_kind <= emit_kind;
      out_hnd  <= emit_hnd;
      out_next <= emit_next;
      out_last <= emit_last;
    end
  end

  assign out_valid    = out_v;
  assign kind         = out_kind;
  assign fired_handle = out_hnd;
  assign next_ms      = out_next;
  assign last         = out_last;

endmodule
